// ----- design/dna_trie_node_insert_top_defines.svh -----
// Assertion helpers for the checker file.
`ifndef DNA_TRIE_NODE_INSERT_TOP_DEFINES_SVH
`define DNA_TRIE_NODE_INSERT_TOP_DEFINES_SVH

// Same-cycle property, sampled on clk, quiet while rst_n is low.
`define DTNI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define DTNI_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/dtni_pkg.sv -----
package dtni_pkg;

  localparam int IDX_W       = 10;
  localparam int TABLE_DEPTH = 1024;
  localparam int CNT_W       = 11;
  localparam int LABEL_W     = 8;
  localparam int PID_W       = 16;
  localparam int BASE_W      = 2;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 80;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [LABEL_W-1:0] ROOT_LABEL = 8'd33;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef logic [3:0][IDX_W-1:0] child_vec_t;

  typedef struct packed {
    op_t               op;
    logic [BASE_W-1:0] base;
    logic [PID_W-1:0]  pid;
    logic              last;
    logic [IDX_W-1:0]  ridx;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [IDX_W-1:0]   node_index;
    logic               created;
    logic               table_full;
    logic               index_valid;
    logic [LABEL_W-1:0] label;
    logic [PID_W-1:0]   entry_id;
    logic               has_id;
    child_vec_t         child;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD_WAIT,
    BK_LOOK,
    BK_NEW,
    BK_EMIT,
    BK_SEND
  } bk_state_t;

endpackage

// ----- design/dtni_front.sv -----
module dtni_front
  import dtni_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 in_tlast,
  input  q_stat_t              q_stat,
  output logic                 push,
  output cmd_t                 cmd
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic accept;

  assign push      = valid_r && !q_stat.full;
  assign in_tready = !valid_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_r;

  // fields that do not apply to the item's kind are dropped here
  always_comb begin
    cmd_nxt   = cmd_r;
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt   = 1'b1;
      cmd_nxt.op  = op_t'(in_tuser);
      if (in_tuser == OP_READ) begin
        cmd_nxt.base = '0;
        cmd_nxt.pid  = '0;
        cmd_nxt.last = 1'b0;
        cmd_nxt.ridx = in_tdata[27:18];
      end else begin
        cmd_nxt.base = in_tdata[1:0];
        cmd_nxt.pid  = in_tdata[17:2];
        cmd_nxt.last = in_tlast;
        cmd_nxt.ridx = '0;
      end
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

// ----- design/dtni_queue.sv -----
module dtni_queue
  import dtni_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    cmd_in,
  input  logic    pop,
  output cmd_t    cmd_out,
  output q_stat_t q_stat
);

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign cmd_out      = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- design/dtni_back.sv -----
module dtni_back
  import dtni_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int ID_BITS   = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    q_cmd,
  input  q_stat_t q_stat,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res
);

  localparam int IdW = (ID_BITS < PID_W) ? ID_BITS : PID_W;
  localparam int Cap = (MAX_NODES < TABLE_DEPTH) ? MAX_NODES : TABLE_DEPTH;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [IdW-1:0]     id;
    logic               has_id;
  } info_t;

  // node entries; root lives in registers, so index 0 is never used here
  info_t      info_mem  [TABLE_DEPTH];
  child_vec_t child_mem [TABLE_DEPTH];
  info_t      info_rd_r;
  child_vec_t child_rd_r;

  logic [IDX_W-1:0] rd_addr;
  logic             info_we;
  logic [IDX_W-1:0] info_waddr;
  info_t            info_wdata;
  logic             child_we;
  logic [IDX_W-1:0] child_waddr;
  child_vec_t       child_wdata;

  bk_state_t          state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  child_vec_t         root_ch_r, root_ch_nxt;
  logic [CNT_W-1:0]   node_cnt_r, node_cnt_nxt;
  logic [IDX_W-1:0]   cursor_r, cursor_nxt;
  logic [LABEL_W-1:0] depth_r, depth_nxt;
  logic [IDX_W-1:0]   nidx_r, nidx_nxt;
  res_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;

  child_vec_t         cur_ch;
  child_vec_t         upd_ch;
  logic [IDX_W-1:0]   look_next;
  logic               look_hit;
  logic               can_alloc;
  logic [IDX_W-1:0]   new_idx;
  info_t              new_info;
  logic [LABEL_W-1:0] depth_fin;
  logic               slot_free;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    cur_ch             = (cursor_r == '0) ? root_ch_r : child_rd_r;
    look_next          = cur_ch[cmd_r.base];
    look_hit           = (look_next != '0);
    can_alloc          = (node_cnt_r < CNT_W'(Cap));
    new_idx            = node_cnt_r[IDX_W-1:0];
    upd_ch             = cur_ch;
    upd_ch[cmd_r.base] = new_idx;
    new_info.label     = depth_r;
    new_info.id        = cmd_r.last ? cmd_r.pid[IdW-1:0] : '0;
    new_info.has_id    = cmd_r.last;
    depth_fin          = cmd_r.last ? '0 : depth_r + 1'b1;
    slot_free          = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (q_cmd.op == OP_READ) ? BK_RD_WAIT : BK_LOOK;
        end
      end
      BK_RD_WAIT: state_nxt = BK_SEND;
      BK_LOOK: begin
        if (look_hit) begin
          state_nxt = BK_EMIT;
        end else if (can_alloc) begin
          state_nxt = BK_NEW;
        end else begin
          state_nxt = BK_SEND;
        end
      end
      BK_NEW:  state_nxt = BK_SEND;
      BK_EMIT: state_nxt = BK_SEND;
      BK_SEND: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    q_pop         = 1'b0;
    rd_addr       = cursor_r;
    info_we       = 1'b0;
    info_waddr    = new_idx;
    info_wdata    = new_info;
    child_we      = 1'b0;
    child_waddr   = cursor_r;
    child_wdata   = upd_ch;
    cmd_nxt       = cmd_r;
    root_ch_nxt   = root_ch_r;
    node_cnt_nxt  = node_cnt_r;
    cursor_nxt    = cursor_r;
    depth_nxt     = depth_r;
    nidx_nxt      = nidx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          rd_addr = (q_cmd.op == OP_READ) ? q_cmd.ridx : cursor_r;
        end
      end
      BK_RD_WAIT: begin
        res_nxt            = '0;
        res_nxt.node_index = cmd_r.ridx;
        if ({1'b0, cmd_r.ridx} < node_cnt_r) begin
          res_nxt.index_valid = 1'b1;
          if (cmd_r.ridx == '0) begin
            res_nxt.label = ROOT_LABEL;
            res_nxt.child = root_ch_r;
          end else begin
            res_nxt.label    = info_rd_r.label;
            res_nxt.entry_id = PID_W'(info_rd_r.id);
            res_nxt.has_id   = info_rd_r.has_id;
            res_nxt.child    = child_rd_r;
          end
        end
      end
      BK_LOOK: begin
        if (look_hit) begin
          nidx_nxt = look_next;
          rd_addr  = look_next;
        end else if (can_alloc) begin
          info_we = 1'b1;
          if (cursor_r == '0) begin
            root_ch_nxt = upd_ch;
          end else begin
            child_we = 1'b1;
          end
          node_cnt_nxt = node_cnt_r + 1'b1;
          nidx_nxt     = new_idx;
        end else begin
          // no room: report the cursor's own entry; cursor stays put unless the symbol is last
          res_nxt            = '0;
          res_nxt.node_index = cursor_r;
          res_nxt.table_full = 1'b1;
          res_nxt.child      = cur_ch;
          if (cursor_r == '0) begin
            res_nxt.label = ROOT_LABEL;
          end else begin
            res_nxt.label    = info_rd_r.label;
            res_nxt.entry_id = PID_W'(info_rd_r.id);
            res_nxt.has_id   = info_rd_r.has_id;
          end
          cursor_nxt = cmd_r.last ? '0 : cursor_r;
          depth_nxt  = depth_fin;
        end
      end
      BK_NEW: begin
        child_we           = 1'b1;
        child_waddr        = nidx_r;
        child_wdata        = '0;
        res_nxt            = '0;
        res_nxt.node_index = nidx_r;
        res_nxt.created    = 1'b1;
        res_nxt.label      = new_info.label;
        res_nxt.entry_id   = PID_W'(new_info.id);
        res_nxt.has_id     = new_info.has_id;
        cursor_nxt         = cmd_r.last ? '0 : nidx_r;
        depth_nxt          = depth_fin;
      end
      BK_EMIT: begin
        res_nxt            = '0;
        res_nxt.node_index = nidx_r;
        res_nxt.label      = info_rd_r.label;
        res_nxt.entry_id   = PID_W'(info_rd_r.id);
        res_nxt.has_id     = info_rd_r.has_id;
        res_nxt.child      = child_rd_r;
        cursor_nxt         = cmd_r.last ? '0 : nidx_r;
        depth_nxt          = depth_fin;
      end
      BK_SEND: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    info_rd_r  <= info_mem[rd_addr];
    child_rd_r <= child_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      root_ch_r   <= '0;
      node_cnt_r  <= CNT_W'(1);
      cursor_r    <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_ch_r   <= root_ch_nxt;
      node_cnt_r  <= node_cnt_nxt;
      cursor_r    <= cursor_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    nidx_r    <= nidx_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

// ----- design/dna_trie_node_insert_top.sv -----
// Channel  Ports                         Carries
// input    in_tvalid/in_tready           insert symbol or node read request
// result   out_tvalid/out_tready         node reached or node read, with its entry
//
// Front end registers and classifies each item, a 4-deep queue feeds the back end.
// Back end takes one item at a time: a read waits on the node memories, then sends;
// an insert looks up the child, then follows it, or writes the parent and clears the
// new node's children, or reports a full table, and sends through the result register.
// Reset (rst_n low, synchronous) leaves only the root; node memories need no clearing.
// Either side may stall freely; the queue and the output register absorb it.
module dna_trie_node_insert_top
  import dtni_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int ID_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // base[1:0], pattern_id[17:2], read_index[27:18]
  input  logic                  in_tuser,   // req_type
  input  logic                  in_tlast,   // last_symbol
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // node_index, created, table_full, index_valid,
                                            // label, entry_id, has_id, child_a, child_c,
                                            // child_t, child_other
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    front_cmd;
  cmd_t    q_cmd;
  res_t    res;

  dtni_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (front_cmd)
  );

  dtni_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (front_cmd),
    .pop     (pop),
    .cmd_out (q_cmd),
    .q_stat  (q_stat)
  );

  dtni_back #(
    .MAX_NODES (MAX_NODES),
    .ID_BITS   (ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (q_cmd),
    .q_stat    (q_stat),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00,
                      res.child[3], res.child[2], res.child[1], res.child[0],
                      res.has_id, res.entry_id, res.label,
                      res.index_valid, res.table_full, res.created,
                      res.node_index};

endmodule

// ----- design/dtni_checker.sv -----
`include "dna_trie_node_insert_top_defines.svh"

module dtni_checker
  import dtni_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // the table never shrinks, so once full it stays full
  logic seen_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_full_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tdata[11]) begin
      seen_full_r <= 1'b1;
    end
  end

  `DTNI_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `DTNI_ASSERT(a_flags_excl, out_tvalid |-> !(out_tdata[10] && out_tdata[11]) && !(out_tdata[12] && (out_tdata[10] || out_tdata[11])), "conflicting result flags")
  `DTNI_ASSERT(a_new_node_blank, out_tvalid && out_tdata[10] |-> out_tdata[77:38] == 40'd0 && out_tdata[9:0] != 10'd0, "new node not blank or is root")
  `DTNI_ASSERT(a_no_alloc_after_full, out_tvalid && seen_full_r |-> !out_tdata[10], "node created after table full")

endmodule

bind dna_trie_node_insert_top dtni_checker u_checker (.*);
